// ----- rtl/core/sm64wh_pkg.sv -----
// Shared constants, codes and control types for the SplitMix64 word hash.
package sm64wh_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = WORD_W / 2;

   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

   localparam int SHIFT_PRE = 30;
   localparam int SHIFT_MID = 27;
   localparam int SHIFT_END = 31;

   // Partial product selection for the shared 32x32 multiplier
   localparam logic [1:0] MUL_LL = 2'd0;   // z low  x k low
   localparam logic [1:0] MUL_LH = 2'd1;   // z low  x k high
   localparam logic [1:0] MUL_HL = 2'd2;   // z high x k low

   // Multiplier constant selection
   localparam logic K_SEL_A = 1'b0;
   localparam logic K_SEL_B = 1'b1;

   typedef struct packed {
      logic       load;      // take a request beat, update chain value
      logic [1:0] mul_sel;   // partial product to form this cycle
      logic       k_sel;     // which mixing constant
      logic       sum_load;  // sum := registered product
      logic       sum_add;   // sum += registered product << 32
      logic       z_mix;     // z := sum ^ (sum >> 27)
      logic       fin;       // fold result into accumulator, emit on last
   } cmd_type;

   typedef struct packed {
      logic last;            // word in flight carries the last flag
      logic out_full;        // result register holds a beat that is stalled
   } status_type;

endpackage

// ----- rtl/core/sm64wh_dpath.sv -----
// Datapath: seed, chain, accumulator, shared multiplier and result register.
module sm64wh_dpath
   import sm64wh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                csr_valid,
   input  logic [WORD_W-1:0]   csr_initial_seed,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_digest
);

   logic [WORD_W-1:0]   seed_ff;
   logic                in_msg_ff;
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_digest_ff;
   logic [WORD_W-1:0]   chain_ff;
   logic [WORD_W-1:0]   acc_ff;
   logic [WORD_W-1:0]   z_ff;
   logic [WORD_W-1:0]   mul_ff;
   logic [WORD_W-1:0]   sum_ff;
   logic                last_ff;

   logic [WORD_W-1:0]   chain_in;
   logic [WORD_W-1:0]   acc_in;
   logic [WORD_W-1:0]   k_val;
   logic [HALF_W-1:0]   op_z;
   logic [HALF_W-1:0]   op_k;
   logic [WORD_W-1:0]   mul_in;

   assign chain_in = ((in_msg_ff ? chain_ff : seed_ff) ^ req_data_word) + GOLDEN_GAMMA;
   assign acc_in   = acc_ff ^ sum_ff ^ (sum_ff >> SHIFT_END);
   assign k_val    = (cmd.k_sel == K_SEL_B) ? MIX_MUL_B : MIX_MUL_A;

   always_comb begin
      case (cmd.mul_sel)
         MUL_LL: begin
            op_z = z_ff[HALF_W-1:0];
            op_k = k_val[HALF_W-1:0];
         end
         MUL_LH: begin
            op_z = z_ff[HALF_W-1:0];
            op_k = k_val[WORD_W-1:HALF_W];
         end
         default: begin
            op_z = z_ff[WORD_W-1:HALF_W];
            op_k = k_val[HALF_W-1:0];
         end
      endcase
   end

   assign mul_in = {{HALF_W{1'b0}}, op_z} * {{HALF_W{1'b0}}, op_k};

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_initial_seed;
         end
         if (cmd.load) begin
            in_msg_ff <= 1'b1;
         end else if (cmd.fin && last_ff) begin
            in_msg_ff <= 1'b0;
         end
         if (cmd.fin && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (cmd.load) begin
         chain_ff <= chain_in;
         z_ff     <= chain_in ^ (chain_in >> SHIFT_PRE);
         last_ff  <= req_last;
         if (!in_msg_ff) begin
            acc_ff <= '0;
         end
      end else if (cmd.z_mix) begin
         z_ff <= sum_ff ^ (sum_ff >> SHIFT_MID);
      end
      if (cmd.sum_load) begin
         sum_ff <= mul_ff;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + {mul_ff[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      if (cmd.fin) begin
         acc_ff <= acc_in;
         if (last_ff) begin
            rsp_digest_ff <= acc_in;
         end
      end
   end

   assign status.last     = last_ff;
   assign status.out_full = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest      = rsp_digest_ff;

endmodule

// ----- rtl/core/sm64wh_ctrl.sv -----
// Controller: sequences one word through load, two multiplies and the fold.
module sm64wh_ctrl
   import sm64wh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  status_type  status,
   output cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MA0  = 4'd1;
   localparam logic [3:0] ST_MA1  = 4'd2;
   localparam logic [3:0] ST_MA2  = 4'd3;
   localparam logic [3:0] ST_MA3  = 4'd4;
   localparam logic [3:0] ST_MIX  = 4'd5;
   localparam logic [3:0] ST_MB0  = 4'd6;
   localparam logic [3:0] ST_MB1  = 4'd7;
   localparam logic [3:0] ST_MB2  = 4'd8;
   localparam logic [3:0] ST_MB3  = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_MA0;
            end
         end
         ST_MA0: begin
            cmd.mul_sel = MUL_LL;
            state_in    = ST_MA1;
         end
         ST_MA1: begin
            cmd.mul_sel  = MUL_LH;
            cmd.sum_load = 1'b1;
            state_in     = ST_MA2;
         end
         ST_MA2: begin
            cmd.mul_sel = MUL_HL;
            cmd.sum_add = 1'b1;
            state_in    = ST_MA3;
         end
         ST_MA3: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_MIX;
         end
         ST_MIX: begin
            cmd.z_mix = 1'b1;
            state_in  = ST_MB0;
         end
         ST_MB0: begin
            cmd.mul_sel = MUL_LL;
            cmd.k_sel   = K_SEL_B;
            state_in    = ST_MB1;
         end
         ST_MB1: begin
            cmd.mul_sel  = MUL_LH;
            cmd.k_sel    = K_SEL_B;
            cmd.sum_load = 1'b1;
            state_in     = ST_MB2;
         end
         ST_MB2: begin
            cmd.mul_sel = MUL_HL;
            cmd.k_sel   = K_SEL_B;
            cmd.sum_add = 1'b1;
            state_in    = ST_MB3;
         end
         ST_MB3: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            // hold while a stalled digest still occupies the result register
            if (!(status.last && status.out_full)) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- rtl/core/splitmix64_word_hash_core.sv -----
// Top level of the SplitMix64 word hash: controller plus datapath.
//
// Hashes a message streamed in as 64-bit words. Each request beat carries
// one word and a last flag; the chain value of a message starts at the
// seed held in the csr register, takes each word by XOR, then adds the
// golden-ratio constant, and the SplitMix64 finaliser of the new chain
// value is XORed into an accumulator. The beat marked last yields exactly
// one response beat carrying the accumulator as the digest; every other
// word yields none. A request beat is taken only while the block is idle:
// it loads the word, performs two 64-bit multiplies mod 2^64, each built
// from three 32x32 partial products on one shared, registered multiplier,
// mixes between them and folds the result into the accumulator. The
// digest sits in an output register, so the next word is accepted while
// a digest still waits for the consumer; only the fold of a further last
// word holds until that register is free. Seed writes (csr_ready is always
// high) take effect from the next message on; write them only while the
// block is idle.
module splitmix64_word_hash_core
   import sm64wh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration: initial seed
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WORD_W-1:0]   csr_initial_seed,
   // request beats: message words
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic                req_last,
   // response beats: digests
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_digest
);

   cmd_type    cmd;
   status_type status;

   // the seed register takes a write in any cycle
   assign csr_ready = 1'b1;

   sm64wh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sm64wh_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_initial_seed (csr_initial_seed),
      .req_data_word    (req_data_word),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest       (rsp_digest)
   );

endmodule
